@@ rtl/lnedit_pkg.sv @@
// Shared constants and types for the line editor with escape keys.
`timescale 1ns / 1ps

package lnedit_pkg;

   // Default line capacity and the fixed widths of the line fields.
   localparam int LINE_CAPACITY_DEF = 32;
   localparam int CNT_W  = 6;
   localparam int CHAR_W = 7;
   localparam int BYTE_W = 8;
   localparam int EV_W   = 3;

   // Event codes reported with each result.
   localparam logic [EV_W-1:0] EV_NONE = 3'd0;
   localparam logic [EV_W-1:0] EV_INS  = 3'd1;
   localparam logic [EV_W-1:0] EV_DEL  = 3'd2;
   localparam logic [EV_W-1:0] EV_MOVE = 3'd3;
   localparam logic [EV_W-1:0] EV_CHAR = 3'd4;
   localparam logic [EV_W-1:0] EV_END  = 3'd5;
   localparam logic [EV_W-1:0] EV_FULL = 3'd6;

   // Terminal key codes.
   localparam logic [BYTE_W-1:0] KEY_BS        = 8'd8;
   localparam logic [BYTE_W-1:0] KEY_LF        = 8'd10;
   localparam logic [BYTE_W-1:0] KEY_CR        = 8'd13;
   localparam logic [BYTE_W-1:0] KEY_ESC       = 8'd27;
   localparam logic [BYTE_W-1:0] KEY_RUBOUT    = 8'd127;
   localparam logic [BYTE_W-1:0] KEY_PRINT_LO  = 8'd32;
   localparam logic [BYTE_W-1:0] KEY_PRINT_HI  = 8'd126;
   localparam logic [BYTE_W-1:0] KEY_LBRACKET  = 8'h5B;
   localparam logic [BYTE_W-1:0] KEY_LEFT      = 8'h44;
   localparam logic [BYTE_W-1:0] KEY_RIGHT     = 8'h43;
   localparam logic [BYTE_W-1:0] KEY_HOME      = 8'h48;
   localparam logic [BYTE_W-1:0] KEY_END       = 8'h46;
   localparam logic [BYTE_W-1:0] KEY_TILDE     = 8'h7E;
   localparam logic [BYTE_W-1:0] KEY_DIGIT_LO  = 8'h30;
   localparam logic [BYTE_W-1:0] KEY_DIGIT_HI  = 8'h39;

   // Digits that select an action in a tilde sequence.
   localparam logic [3:0] DIGIT_HOME   = 4'd1;
   localparam logic [3:0] DIGIT_DELETE = 4'd3;
   localparam logic [3:0] DIGIT_END    = 4'd4;

   // One result as it leaves the sequencer.
   typedef struct packed {
      logic              strobe;
      logic [EV_W-1:0]   event_res;
      logic [BYTE_W-1:0] char_out;
      logic [CNT_W-1:0]  cursor_pos;
      logic [CNT_W-1:0]  line_length;
      logic              last;
   } result_type;

endpackage

@@ rtl/lnedit_ram.sv @@
// Generic single-clock RAM with one write port and one registered read port.
`timescale 1ns / 1ps

module lnedit_ram #(
   parameter int WIDTH = 7,
   parameter int DEPTH = 32,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/lnedit_ctrl.sv @@
// Key decoder and sequencer that edits the line held in the line RAM.
`timescale 1ns / 1ps

module lnedit_ctrl
   import lnedit_pkg::*;
#(
   parameter int LINE_CAPACITY = LINE_CAPACITY_DEF,
   localparam int ADDR_W = (LINE_CAPACITY > 1) ? $clog2(LINE_CAPACITY) : 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [BYTE_W-1:0] req_key_byte,
   output logic              busy,
   output logic              ram_we,
   output logic [ADDR_W-1:0] ram_waddr,
   output logic [CHAR_W-1:0] ram_wdata,
   output logic [ADDR_W-1:0] ram_raddr,
   input  logic [CHAR_W-1:0] ram_rdata,
   output result_type        rsp
);

   localparam logic [CNT_W-1:0] CAP = CNT_W'(LINE_CAPACITY);
   localparam logic [CNT_W-1:0] ONE = CNT_W'(1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SHIFT,
      ST_READ
   } state_type;

   typedef enum logic [1:0] {
      ESC_IDLE,
      ESC_SEEN,
      ESC_BRACKET,
      ESC_DIGIT
   } esc_type;

   state_type         state_ff, state_in;
   esc_type           phase_ff, phase_in;
   logic [3:0]        digit_ff, digit_in;
   logic [CNT_W-1:0]  len_ff, len_in;
   logic [CNT_W-1:0]  cur_ff, cur_in;
   logic [CNT_W-1:0]  rd_ff, rd_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [CNT_W-1:0]  num_ff, num_in;
   logic [CNT_W-1:0]  pos_ff, pos_in;
   logic [CNT_W-1:0]  wa_ff, wa_in;
   logic [CHAR_W-1:0] ch_ff, ch_in;
   logic [EV_W-1:0]   ev_ff, ev_in;
   logic              up_ff, up_in;
   logic              wv_ff, wv_in;
   logic              wsrc_ff, wsrc_in;
   logic              chv_ff, chv_in;
   result_type        rsp_ff, rsp_in;
   logic [BYTE_W-1:0] key;

   assign key = req_key_byte;

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      digit_in = digit_ff;
      len_in   = len_ff;
      cur_in   = cur_ff;
      rd_in    = rd_ff;
      cnt_in   = cnt_ff;
      num_in   = num_ff;
      pos_in   = pos_ff;
      wa_in    = wa_ff;
      ch_in    = ch_ff;
      ev_in    = ev_ff;
      up_in    = up_ff;
      wv_in    = 1'b0;
      wsrc_in  = 1'b0;
      chv_in   = 1'b0;
      rsp_in   = '0;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               // By default a byte gives one result with no change.
               rsp_in.strobe    = 1'b1;
               rsp_in.event_res = EV_NONE;
               rsp_in.last      = 1'b1;
               if (phase_ff != ESC_IDLE) begin
                  case (phase_ff)
                     ESC_SEEN: begin
                        phase_in = (key == KEY_LBRACKET) ? ESC_BRACKET : ESC_IDLE;
                     end
                     ESC_BRACKET: begin
                        phase_in = ESC_IDLE;
                        if (key == KEY_LEFT) begin
                           if (cur_ff != '0) begin
                              cur_in = cur_ff - ONE;
                              rsp_in.event_res = EV_MOVE;
                           end
                        end else if (key == KEY_RIGHT) begin
                           if (cur_ff < len_ff) begin
                              cur_in = cur_ff + ONE;
                              rsp_in.event_res = EV_MOVE;
                           end
                        end else if (key == KEY_HOME) begin
                           cur_in = '0;
                           rsp_in.event_res = EV_MOVE;
                        end else if (key == KEY_END) begin
                           cur_in = len_ff;
                           rsp_in.event_res = EV_MOVE;
                        end else if (key >= KEY_DIGIT_LO && key <= KEY_DIGIT_HI) begin
                           digit_in = key[3:0];
                           phase_in = ESC_DIGIT;
                        end
                     end
                     default: begin
                        phase_in = ESC_IDLE;
                        if (key == KEY_TILDE) begin
                           if (digit_ff == DIGIT_HOME) begin
                              cur_in = '0;
                              rsp_in.event_res = EV_MOVE;
                           end else if (digit_ff == DIGIT_END) begin
                              cur_in = len_ff;
                              rsp_in.event_res = EV_MOVE;
                           end else if (digit_ff == DIGIT_DELETE && cur_ff < len_ff) begin
                              // Delete at the cursor: close the gap from above.
                              rsp_in   = '0;
                              len_in   = len_ff - ONE;
                              cnt_in   = len_ff - cur_ff - ONE;
                              rd_in    = cur_ff + ONE;
                              up_in    = 1'b0;
                              ev_in    = EV_DEL;
                              state_in = ST_SHIFT;
                           end
                        end
                     end
                  endcase
               end else if (key == KEY_CR || key == KEY_LF) begin
                  rsp_in   = '0;
                  num_in   = len_ff;
                  len_in   = '0;
                  cur_in   = '0;
                  rd_in    = '0;
                  state_in = ST_READ;
               end else if (key == KEY_BS || key == KEY_RUBOUT) begin
                  if (cur_ff != '0) begin
                     rsp_in   = '0;
                     len_in   = len_ff - ONE;
                     cur_in   = cur_ff - ONE;
                     cnt_in   = len_ff - cur_ff;
                     rd_in    = cur_ff;
                     up_in    = 1'b0;
                     ev_in    = EV_DEL;
                     state_in = ST_SHIFT;
                  end
               end else if (key == KEY_ESC) begin
                  phase_in = ESC_SEEN;
               end else if (key >= KEY_PRINT_LO && key <= KEY_PRINT_HI) begin
                  if (len_ff >= CAP) begin
                     rsp_in.event_res = EV_FULL;
                  end else begin
                     // Open a gap at the cursor, then write the byte into it.
                     rsp_in   = '0;
                     cnt_in   = len_ff - cur_ff;
                     rd_in    = len_ff - ONE;
                     pos_in   = cur_ff;
                     ch_in    = key[CHAR_W-1:0];
                     len_in   = len_ff + ONE;
                     cur_in   = cur_ff + ONE;
                     up_in    = 1'b1;
                     ev_in    = EV_INS;
                     state_in = ST_SHIFT;
                  end
               end
               if (rsp_in.strobe) begin
                  rsp_in.cursor_pos  = cur_in;
                  rsp_in.line_length = len_in;
               end
            end
         end

         ST_SHIFT: begin
            if (cnt_ff != '0) begin
               wv_in  = 1'b1;
               wa_in  = up_ff ? rd_ff + ONE : rd_ff - ONE;
               rd_in  = up_ff ? rd_ff - ONE : rd_ff + ONE;
               cnt_in = cnt_ff - ONE;
            end else begin
               if (up_ff) begin
                  wv_in   = 1'b1;
                  wsrc_in = 1'b1;
                  wa_in   = pos_ff;
               end
               rsp_in.strobe      = 1'b1;
               rsp_in.event_res   = ev_ff;
               rsp_in.cursor_pos  = cur_ff;
               rsp_in.line_length = len_ff;
               rsp_in.last        = 1'b1;
               state_in           = ST_IDLE;
            end
         end

         ST_READ: begin
            if (chv_ff) begin
               rsp_in.strobe      = 1'b1;
               rsp_in.event_res   = EV_CHAR;
               rsp_in.char_out    = {1'b0, ram_rdata};
               rsp_in.cursor_pos  = cur_ff;
               rsp_in.line_length = len_ff;
            end
            if (rd_ff != num_ff) begin
               chv_in = 1'b1;
               rd_in  = rd_ff + ONE;
            end else if (!chv_ff) begin
               rsp_in.strobe      = 1'b1;
               rsp_in.event_res   = EV_END;
               rsp_in.char_out    = KEY_LF;
               rsp_in.cursor_pos  = cur_ff;
               rsp_in.line_length = len_ff;
               rsp_in.last        = 1'b1;
               state_in           = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         phase_ff <= ESC_IDLE;
         digit_ff <= '0;
         len_ff   <= '0;
         cur_ff   <= '0;
         wv_ff    <= 1'b0;
         chv_ff   <= 1'b0;
         rsp_ff   <= '0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         digit_ff <= digit_in;
         len_ff   <= len_in;
         cur_ff   <= cur_in;
         wv_ff    <= wv_in;
         chv_ff   <= chv_in;
         rsp_ff   <= rsp_in;
      end
      rd_ff   <= rd_in;
      cnt_ff  <= cnt_in;
      num_ff  <= num_in;
      pos_ff  <= pos_in;
      wa_ff   <= wa_in;
      ch_ff   <= ch_in;
      ev_ff   <= ev_in;
      up_ff   <= up_in;
      wsrc_ff <= wsrc_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign ram_we    = wv_ff;
   assign ram_waddr = wa_ff[ADDR_W-1:0];
   assign ram_wdata = wsrc_ff ? ch_ff : ram_rdata;
   assign ram_raddr = rd_ff[ADDR_W-1:0];
   assign rsp       = rsp_ff;

endmodule

@@ rtl/line_editor_with_escape_keys_core.sv @@
// Top level of the line editor: sequencer plus the line RAM.
`timescale 1ns / 1ps

// A byte that only moves state gives its result in the cycle after the transfer.
// Edits walk one RAM entry per cycle, and the result follows the last move. CR or LF
// keeps busy high while the line is read out. Results cannot be held off; reset empties
// the line, homes the cursor and leaves escape parsing idle.
module line_editor_with_escape_keys_core
   import lnedit_pkg::*;
#(
   parameter int LINE_CAPACITY = LINE_CAPACITY_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [BYTE_W-1:0] req_key_byte,
   output logic              rsp_strobe,
   output logic [EV_W-1:0]   rsp_event_res,
   output logic [BYTE_W-1:0] rsp_char_out,
   output logic [CNT_W-1:0]  rsp_cursor_pos,
   output logic [CNT_W-1:0]  rsp_line_length,
   output logic              rsp_last
);

   // The line RAM needs an address for each character position.
   localparam int ADDR_W = (LINE_CAPACITY > 1) ? $clog2(LINE_CAPACITY) : 1;

   logic              ram_we;
   logic [ADDR_W-1:0] ram_waddr;
   logic [CHAR_W-1:0] ram_wdata;
   logic [ADDR_W-1:0] ram_raddr;
   logic [CHAR_W-1:0] ram_rdata;
   result_type        rsp;

   // The sequencer owns the cursor, the length and the escape parser. It moves
   // characters through the RAM with a one-deep write pipeline: the entry read in
   // one cycle is written one place over in the next.
   lnedit_ctrl #(
      .LINE_CAPACITY (LINE_CAPACITY)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .req_key_byte (req_key_byte),
      .busy         (busy),
      .ram_we       (ram_we),
      .ram_waddr    (ram_waddr),
      .ram_wdata    (ram_wdata),
      .ram_raddr    (ram_raddr),
      .ram_rdata    (ram_rdata),
      .rsp          (rsp)
   );

   // Line storage. Entries at or beyond the current length are never read back
   // into a result, so the RAM needs no clearing after reset.
   lnedit_ram #(
      .WIDTH (CHAR_W),
      .DEPTH (LINE_CAPACITY)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // Each result comes straight from the sequencer's output register.
   assign rsp_strobe      = rsp.strobe;
   assign rsp_event_res   = rsp.event_res;
   assign rsp_char_out    = rsp.char_out;
   assign rsp_cursor_pos  = rsp.cursor_pos;
   assign rsp_line_length = rsp.line_length;
   assign rsp_last        = rsp.last;

endmodule

@@ tb/tb_line_editor_with_escape_keys_core.sv @@
// Self-checking testbench for the line editor core: byte stimulus, line predictor, result checks.
`timescale 1ns / 1ps

module tb_line_editor_with_escape_keys_core;
   import lnedit_pkg::*;

   localparam int LINE_CAP = LINE_CAPACITY_DEF;

   // Where the escape parser stands between bytes.
   typedef enum logic [1:0] {
      ESC_IDLE,
      ESC_AFTER_ESC,
      ESC_AFTER_BRACKET,
      ESC_AFTER_DIGIT
   } esc_state_type;

   // The shadow line holds its own copy of the buffer, cursor and escape
   // state. Every accepted byte is run through it, and the results that the
   // byte must cause are queued in order. Results from the block are then
   // checked against the oldest queued entry, one field at a time.
   class line_shadow;
      logic [CHAR_W-1:0] chars [LINE_CAP];
      logic [CNT_W-1:0]  len;
      logic [CNT_W-1:0]  cur;
      esc_state_type     esc;
      logic [3:0]        digit;
      result_type        due_results[$];
      int                errors;

      function new();
         len    = '0;
         cur    = '0;
         esc    = ESC_IDLE;
         digit  = '0;
         errors = 0;
         foreach (chars[i]) chars[i] = '0;
      endfunction

      // Every result carries the cursor and length as they stand after the byte.
      function void push(logic [EV_W-1:0] ev, logic [BYTE_W-1:0] ch, logic fin);
         result_type r;
         r.strobe      = 1'b1;
         r.event_res   = ev;
         r.char_out    = ch;
         r.cursor_pos  = cur;
         r.line_length = len;
         r.last        = fin;
         due_results.push_back(r);
      endfunction

      function logic [EV_W-1:0] remove_char(logic [CNT_W-1:0] pos);
         if (pos >= len) return EV_NONE;
         for (int i = pos; i + 1 < len; i++) chars[i] = chars[i + 1];
         len = len - 1'b1;
         return EV_DEL;
      endfunction

      function logic [EV_W-1:0] take_escape(logic [BYTE_W-1:0] key);
         logic [EV_W-1:0] ev;
         ev = EV_NONE;
         case (esc)
            ESC_AFTER_ESC: begin
               esc = (key == KEY_LBRACKET) ? ESC_AFTER_BRACKET : ESC_IDLE;
            end
            ESC_AFTER_BRACKET: begin
               esc = ESC_IDLE;
               if (key == KEY_LEFT) begin
                  if (cur > 0) begin
                     cur = cur - 1'b1;
                     ev  = EV_MOVE;
                  end
               end else if (key == KEY_RIGHT) begin
                  if (cur < len) begin
                     cur = cur + 1'b1;
                     ev  = EV_MOVE;
                  end
               end else if (key == KEY_HOME) begin
                  cur = '0;
                  ev  = EV_MOVE;
               end else if (key == KEY_END) begin
                  cur = len;
                  ev  = EV_MOVE;
               end else if (key >= KEY_DIGIT_LO && key <= KEY_DIGIT_HI) begin
                  digit = 4'(key - KEY_DIGIT_LO);
                  esc   = ESC_AFTER_DIGIT;
               end
            end
            default: begin
               esc = ESC_IDLE;
               if (key == KEY_TILDE) begin
                  if (digit == DIGIT_HOME) begin
                     cur = '0;
                     ev  = EV_MOVE;
                  end else if (digit == DIGIT_END) begin
                     cur = len;
                     ev  = EV_MOVE;
                  end else if (digit == DIGIT_DELETE) begin
                     ev = remove_char(cur);
                  end
               end
            end
         endcase
         return ev;
      endfunction

      function void note_key(logic [BYTE_W-1:0] key);
         logic [EV_W-1:0]  ev;
         logic [CNT_W-1:0] n;
         ev = EV_NONE;
         if (esc != ESC_IDLE) begin
            ev = take_escape(key);
         end else if (key == KEY_CR || key == KEY_LF) begin
            // The line is cleared first, so every readout result reports zeros.
            n   = len;
            len = '0;
            cur = '0;
            for (int i = 0; i < n; i++) push(EV_CHAR, {1'b0, chars[i]}, 1'b0);
            push(EV_END, KEY_LF, 1'b1);
            return;
         end else if (key == KEY_BS || key == KEY_RUBOUT) begin
            if (cur > 0) begin
               ev = remove_char(cur - 1'b1);
               if (ev == EV_DEL) cur = cur - 1'b1;
            end
         end else if (key == KEY_ESC) begin
            esc = ESC_AFTER_ESC;
         end else if (key >= KEY_PRINT_LO && key <= KEY_PRINT_HI) begin
            if (len >= LINE_CAP) begin
               ev = EV_FULL;
            end else begin
               for (int i = len; i > cur; i--) chars[i] = chars[i - 1];
               chars[cur] = key[CHAR_W-1:0];
               cur = cur + 1'b1;
               len = len + 1'b1;
               ev  = EV_INS;
            end
         end
         push(ev, '0, 1'b1);
      endfunction

      task flag_mismatch(string what);
         $display("%0t ns: mismatch: %s", $realtime, what);
         errors++;
      endtask

      task check_result(result_type got);
         result_type exp;
         if (due_results.size() == 0) begin
            flag_mismatch($sformatf("unexpected result, event %0d", got.event_res));
            return;
         end
         exp = due_results.pop_front();
         if (got.event_res != exp.event_res)
            flag_mismatch($sformatf("event %0d, expected %0d", got.event_res, exp.event_res));
         if (got.char_out != exp.char_out)
            flag_mismatch($sformatf("char %0d, expected %0d", got.char_out, exp.char_out));
         if (got.cursor_pos != exp.cursor_pos)
            flag_mismatch($sformatf("cursor %0d, expected %0d", got.cursor_pos,
                                    exp.cursor_pos));
         if (got.line_length != exp.line_length)
            flag_mismatch($sformatf("length %0d, expected %0d", got.line_length,
                                    exp.line_length));
         if (got.last != exp.last)
            flag_mismatch($sformatf("last %0b, expected %0b", got.last, exp.last));
      endtask
   endclass

   // Every input is at a known value from time zero; reset is held from the start.
   logic              clock        = 1'b0;
   logic              reset        = 1'b1;
   logic              start        = 1'b0;
   logic [BYTE_W-1:0] req_key_byte = '0;
   logic              busy;
   logic              rsp_strobe;
   logic [EV_W-1:0]   rsp_event_res;
   logic [BYTE_W-1:0] rsp_char_out;
   logic [CNT_W-1:0]  rsp_cursor_pos;
   logic [CNT_W-1:0]  rsp_line_length;
   logic              rsp_last;

   line_shadow board = new();
   int         keys_sent = 0;
   int         idle_pct  = 33;

   line_editor_with_escape_keys_core #(.LINE_CAPACITY(LINE_CAP)) uut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_key_byte    (req_key_byte),
      .rsp_strobe      (rsp_strobe),
      .rsp_event_res   (rsp_event_res),
      .rsp_char_out    (rsp_char_out),
      .rsp_cursor_pos  (rsp_cursor_pos),
      .rsp_line_length (rsp_line_length),
      .rsp_last        (rsp_last)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Results cannot be held off, so every strobed cycle is one transfer. The
   // ports are read at the rising edge, before the block updates them.
   always @(posedge clock) begin
      if (!reset && rsp_strobe)
         board.check_result('{strobe: 1'b1, event_res: rsp_event_res, char_out: rsp_char_out,
                              cursor_pos: rsp_cursor_pos, line_length: rsp_line_length,
                              last: rsp_last});
   end

   // Offers one byte and waits for the transfer. Start stays high into the
   // next call unless the sender decides to idle, so back-to-back bytes see
   // no gap at all. Idle stretches are mostly short, now and then long enough
   // to let a full readout run out with start low.
   task automatic send_key(input logic [BYTE_W-1:0] key);
      int unsigned gap;
      req_key_byte <= key;
      start        <= 1'b1;
      do @(posedge clock); while (busy);
      board.note_key(key);
      keys_sent++;
      if ($urandom_range(0, 99) < idle_pct) begin
         gap = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 40) : $urandom_range(1, 3);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_csi(input logic [BYTE_W-1:0] final_key);
      send_key(KEY_ESC);
      send_key(KEY_LBRACKET);
      send_key(final_key);
   endtask

   task automatic send_tilde(input logic [BYTE_W-1:0] digit_key);
      send_csi(digit_key);
      send_key(KEY_TILDE);
   endtask

   function automatic logic [BYTE_W-1:0] any_printable();
      return BYTE_W'($urandom_range(KEY_PRINT_LO, KEY_PRINT_HI));
   endfunction

   // One random edit: mostly well-formed keys and sequences with random
   // content, plus some noise bytes and escape sequences cut short.
   task automatic send_random_edit();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
         send_key(any_printable());
      end else if (pick < 60) begin
         case ($urandom_range(0, 3))
            0:       send_csi(KEY_LEFT);
            1:       send_csi(KEY_RIGHT);
            2:       send_csi(KEY_HOME);
            default: send_csi(KEY_END);
         endcase
      end else if (pick < 68) begin
         // Mostly the three digits that act, sometimes any digit at all.
         case ($urandom_range(0, 4))
            0:       send_tilde(KEY_DIGIT_LO + DIGIT_HOME);
            1:       send_tilde(KEY_DIGIT_LO + DIGIT_END);
            2, 3:    send_tilde(KEY_DIGIT_LO + DIGIT_DELETE);
            default: send_tilde(BYTE_W'($urandom_range(KEY_DIGIT_LO, KEY_DIGIT_HI)));
         endcase
      end else if (pick < 76) begin
         send_key($urandom_range(0, 1) ? KEY_BS : KEY_RUBOUT);
      end else if (pick < 80) begin
         send_key($urandom_range(0, 1) ? KEY_CR : KEY_LF);
      end else if (pick < 82) begin
         // A burst that can fill the line and run into the full case.
         repeat ($urandom_range(LINE_CAP - 2, LINE_CAP + 4)) send_key(any_printable());
      end else if (pick < 92) begin
         send_key(BYTE_W'($urandom_range(0, 255)));
      end else begin
         send_key(KEY_ESC);
         case ($urandom_range(0, 2))
            0: ;
            1: send_key(KEY_LBRACKET);
            default: begin
               send_key(KEY_LBRACKET);
               send_key(BYTE_W'($urandom_range(KEY_DIGIT_LO, KEY_DIGIT_HI)));
            end
         endcase
         send_key(BYTE_W'($urandom_range(0, 255)));
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: no-effect keys on an empty line, the printable
      // extremes, bytes that are ignored, every cursor and delete sequence,
      // an escape eaten by an escape, and readouts of a non-empty and an empty line.
      send_key(KEY_BS);
      send_csi(KEY_LEFT);
      send_key(KEY_PRINT_LO);
      send_key(KEY_PRINT_HI);
      send_key(8'hFF);
      send_key(8'h00);
      send_csi(KEY_HOME);
      send_key(8'h41);
      send_tilde(KEY_DIGIT_LO + DIGIT_DELETE);
      send_tilde(KEY_DIGIT_LO + DIGIT_END);
      send_key(KEY_RUBOUT);
      send_tilde(KEY_DIGIT_LO + DIGIT_HOME);
      send_csi(KEY_END);
      send_csi(KEY_RIGHT);
      send_key(KEY_ESC);
      send_key(KEY_ESC);
      send_key(KEY_CR);
      send_key(KEY_CR);
      send_key(KEY_LF);

      // Random part in three stretches: sender idles often, then very
      // often, then never.
      while (keys_sent < 470) begin
         if (keys_sent < 180)      idle_pct = 33;
         else if (keys_sent < 330) idle_pct = 69;
         else                      idle_pct = 0;
         send_random_edit();
      end
      start <= 1'b0;

      // Drain: a full readout is the longest the block can keep going.
      while (board.due_results.size() != 0) @(posedge clock);
      repeat (LINE_CAP + 4) @(posedge clock);

      if (board.errors == 0)
         $display("tb_line_editor_with_escape_keys_core OK");
      else
         $display("tb_line_editor_with_escape_keys_core NOT OK");
      $finish;
   end

   // Ends the run as failed if it does not finish in time.
   initial begin
      #5_000_000;
      $display("tb_line_editor_with_escape_keys_core NOT OK");
      $finish;
   end

endmodule
